>>> src/pcf_pkg.sv
package pcf_pkg;

   // field widths of the request and response
   localparam int INDEX_W  = 8;
   localparam int COLOR_W  = 16;
   localparam int WEIGHT_W = 5;

   // request function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   // packed color layout: green in the high half, red and blue in the low half
   localparam logic [31:0] PACK_MASK = 32'h07e0_f81f;

   // full blend weight, one more than the largest register value
   localparam logic [WEIGHT_W:0] WEIGHT_FULL = (WEIGHT_W + 1)'(32);

   // palette write port
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] addr;
      logic [COLOR_W-1:0] data;
   } write_type;

endpackage

>>> src/pcf_ifs.sv
// request channel: palette writes and pixel lookups
interface pcf_req_if;
   logic                        valid;
   logic                        ready;
   logic                        func;
   logic                        palette_select;
   logic [pcf_pkg::INDEX_W-1:0] entry_index;
   logic [pcf_pkg::COLOR_W-1:0] entry_color;
   logic [pcf_pkg::INDEX_W-1:0] first_index;
   logic [pcf_pkg::INDEX_W-1:0] second_index;

   modport source (
      output valid, func, palette_select, entry_index, entry_color,
             first_index, second_index,
      input  ready
   );
   modport sink (
      input  valid, func, palette_select, entry_index, entry_color,
             first_index, second_index,
      output ready
   );
endinterface

// response channel: one blended pixel
interface pcf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [pcf_pkg::COLOR_W-1:0] out_pixel;

   modport source (output valid, out_pixel, input ready);
   modport sink (input valid, out_pixel, output ready);
endinterface

// control register write channel
interface pcf_csr_if;
   logic                         valid;
   logic                         ready;
   logic [pcf_pkg::WEIGHT_W-1:0] blend_weight;

   modport source (output valid, blend_weight, input ready);
   modport sink (input valid, blend_weight, output ready);
endinterface

>>> src/palette_crossfade_rgb565_core.sv
// Cross-fades two palette-indexed images into byte-swapped RGB565. A request
// with func = write stores entry_color into the palette picked by
// palette_select and gives no response; a request with func = pixel looks up
// first_index and second_index, blends the two colors with the weight in
// csr blend_weight as (a*(32-w)+b*w)/32 per channel and returns one pixel,
// high and low bytes swapped. One request is taken every clock while the
// response channel is not stalled; a pixel goes from the registered palette
// reads through the blend into the result register. A palette entry must be
// written before a pixel reads it; indexes at or past PALETTE_ENTRIES are
// dropped on write and read as black. The weight register resets to zero; the
// user must write it only while no pixel is in flight; the block does not check.
module palette_crossfade_rgb565_core #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic      clock,
   input  logic      reset,
   pcf_req_if.sink   req_ch,
   pcf_rsp_if.source rsp_ch,
   pcf_csr_if.sink   csr_ch
);

   logic                         req_accept;
   logic                         is_pixel;
   logic                         s1_advance;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [pcf_pkg::COLOR_W-1:0]  rsp_pixel_ff;
   logic [pcf_pkg::WEIGHT_W-1:0] weight_ff;
   logic [pcf_pkg::WEIGHT_W-1:0] weight_in;
   pcf_pkg::write_type           first_wr;
   pcf_pkg::write_type           second_wr;
   logic [pcf_pkg::COLOR_W-1:0]  first_color;
   logic [pcf_pkg::COLOR_W-1:0]  second_color;
   logic [pcf_pkg::COLOR_W-1:0]  mix_pixel;

   // handshakes
   assign s1_advance   = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign is_pixel     = (req_ch.func == pcf_pkg::FUNC_PIXEL);
   assign csr_ch.ready = 1'b1;

   // palette write ports
   always_comb begin
      first_wr.en    = req_accept && !is_pixel && !req_ch.palette_select;
      first_wr.addr  = req_ch.entry_index;
      first_wr.data  = req_ch.entry_color;
      second_wr.en   = req_accept && !is_pixel && req_ch.palette_select;
      second_wr.addr = req_ch.entry_index;
      second_wr.data = req_ch.entry_color;
   end

   pcf_palette_ram #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_first_ram (
      .clock    (clock),
      .wr       (first_wr),
      .rd_en    (req_accept && is_pixel),
      .rd_addr  (req_ch.first_index),
      .rd_color (first_color)
   );

   pcf_palette_ram #(
      .ENTRIES (PALETTE_ENTRIES)
   ) u_second_ram (
      .clock    (clock),
      .wr       (second_wr),
      .rd_en    (req_accept && is_pixel),
      .rd_addr  (req_ch.second_index),
      .rd_color (second_color)
   );

   pcf_mix u_mix (
      .first_color  (first_color),
      .second_color (second_color),
      .weight       (weight_ff),
      .pixel        (mix_pixel)
   );

   // next state of the lookup stage, result stage and weight register
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      weight_in    = weight_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (req_ch.ready) begin
         s1_valid_in = req_accept && is_pixel;
      end
      if (csr_ch.valid) begin
         weight_in = csr_ch.blend_weight;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         weight_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         weight_ff    <= weight_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         rsp_pixel_ff <= mix_pixel;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_pixel = rsp_pixel_ff;

   // a pixel request always reaches the lookup stage
   a_pixel_enters: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_pixel) |=> s1_valid_ff)
      else $error("pixel request lost before lookup stage");

   // a palette write never turns into a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_pixel) |=> !s1_valid_ff)
      else $error("palette write produced a lookup");

   // a stalled lookup keeps its colors
   a_lookup_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=>
         (s1_valid_ff && $stable(first_color) && $stable(second_color)))
      else $error("stalled lookup stage changed");

   // a lookup that moves on lands in the result register
   a_lookup_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_advance) |=> rsp_valid_ff)
      else $error("lookup dropped on its way to the result register");

   // weight register takes the written value
   a_weight_write: assert property (@(posedge clock) disable iff (reset)
      csr_ch.valid |=> (weight_ff == $past(csr_ch.blend_weight)))
      else $error("blend weight write lost");

endmodule

>>> src/pcf_palette_ram.sv
module pcf_palette_ram #(
   parameter int ENTRIES = 256
) (
   input  logic                        clock,
   input  pcf_pkg::write_type          wr,
   input  logic                        rd_en,
   input  logic [pcf_pkg::INDEX_W-1:0] rd_addr,
   output logic [pcf_pkg::COLOR_W-1:0] rd_color
);

   localparam int AW = $clog2(ENTRIES);
   localparam logic [pcf_pkg::INDEX_W:0] LIMIT = (pcf_pkg::INDEX_W + 1)'(ENTRIES);

   logic [pcf_pkg::COLOR_W-1:0] mem [ENTRIES];
   logic [pcf_pkg::COLOR_W-1:0] rd_data_ff;
   logic                        rd_miss_ff;
   logic                        wr_hit;
   logic                        rd_hit;

   // indexes past the end of the palette are dropped on write, read as black
   assign wr_hit = ({1'b0, wr.addr} < LIMIT);
   assign rd_hit = ({1'b0, rd_addr} < LIMIT);

   // write port
   always_ff @(posedge clock) begin
      if (wr.en && wr_hit) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
         rd_miss_ff <= !rd_hit;
      end
   end

   assign rd_color = rd_miss_ff ? '0 : rd_data_ff;

endmodule

>>> src/pcf_mix.sv
module pcf_mix (
   input  logic [pcf_pkg::COLOR_W-1:0]  first_color,
   input  logic [pcf_pkg::COLOR_W-1:0]  second_color,
   input  logic [pcf_pkg::WEIGHT_W-1:0] weight,
   output logic [pcf_pkg::COLOR_W-1:0]  pixel
);

   logic [31:0]                 first_packed;
   logic [31:0]                 second_packed;
   logic [pcf_pkg::WEIGHT_W:0]  first_share;
   logic [31:0]                 blend_sum;
   logic [31:0]                 blended;
   logic [pcf_pkg::COLOR_W-1:0] folded;

   // spread each color so every channel has headroom above it
   assign first_packed  = ({16'h0, first_color} | {first_color, 16'h0}) & pcf_pkg::PACK_MASK;
   assign second_packed = ({16'h0, second_color} | {second_color, 16'h0}) & pcf_pkg::PACK_MASK;

   // weighted sum of all channels at once, fits in 32 bits
   assign first_share = pcf_pkg::WEIGHT_FULL - {1'b0, weight};
   assign blend_sum   = first_packed * 32'(first_share) + second_packed * 32'(weight);
   assign blended     = (blend_sum >> pcf_pkg::WEIGHT_W) & pcf_pkg::PACK_MASK;

   // fold back to rgb565 and swap bytes
   assign folded = blended[15:0] | blended[31:16];
   assign pixel  = {folded[7:0], folded[15:8]};

endmodule

>>> dv/palette_crossfade_rgb565_core_tb.sv
module palette_crossfade_rgb565_core_tb;

   typedef logic [pcf_pkg::INDEX_W-1:0]  index_type;
   typedef logic [pcf_pkg::COLOR_W-1:0]  color_type;
   typedef logic [pcf_pkg::WEIGHT_W-1:0] weight_type;

   // one request on the input channel
   typedef struct {
      logic      func;
      logic      palette_select;
      index_type entry_index;
      color_type entry_color;
      index_type first_index;
      index_type second_index;
   } request_type;

   logic clock;
   logic reset;

   pcf_req_if req_ch ();
   pcf_rsp_if rsp_ch ();
   pcf_csr_if csr_ch ();

   palette_crossfade_rgb565_core #(
      .PALETTE_ENTRIES(256)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // requests waiting to be offered, pixels waiting to come back
   request_type request_q[$];
   color_type   pixel_q[$];

   // mirror of the block's palettes and weight
   color_type  first_pal_model  [256];
   color_type  second_pal_model [256];
   weight_type weight_model;

   // entries already covered by a queued write, for building legal pixels
   bit        first_written  [256];
   bit        second_written [256];
   index_type first_used[$];
   index_type second_used[$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   logic        hold_arm;
   int unsigned hold_left;
   int          error_count;

   // clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // blend two palette colors the way the block does
   function automatic color_type blend_pixel(color_type color_a,
                                             color_type color_b,
                                             weight_type w);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] share_a;
      logic [31:0] share_b;
      logic [31:0] m;
      color_type   folded;
      a       = ({16'h0000, color_a} | {color_a, 16'h0000}) & pcf_pkg::PACK_MASK;
      b       = ({16'h0000, color_b} | {color_b, 16'h0000}) & pcf_pkg::PACK_MASK;
      share_b = 32'(w);
      share_a = 32'(pcf_pkg::WEIGHT_FULL) - share_b;
      m       = ((a * share_a + b * share_b) >> pcf_pkg::WEIGHT_W) & pcf_pkg::PACK_MASK;
      folded  = m[15:0] | m[31:16];
      return {folded[7:0], folded[15:8]};
   endfunction

   // update the palette mirror or predict a pixel for an accepted request
   function automatic void track_request(request_type r);
      if (r.func == pcf_pkg::FUNC_WRITE) begin
         if (r.palette_select == 1'b0)
            first_pal_model[r.entry_index] = r.entry_color;
         else
            second_pal_model[r.entry_index] = r.entry_color;
      end else begin
         pixel_q.push_back(blend_pixel(first_pal_model[r.first_index],
                                       second_pal_model[r.second_index], weight_model));
      end
   endfunction

   // queue a palette write with random unused fields
   task automatic add_write(logic sel, index_type idx, color_type color);
      request_type r;
      r.func           = pcf_pkg::FUNC_WRITE;
      r.palette_select = sel;
      r.entry_index    = idx;
      r.entry_color    = color;
      r.first_index    = index_type'($urandom);
      r.second_index   = index_type'($urandom);
      request_q.push_back(r);
      if (sel == 1'b0) begin
         if (!first_written[idx]) first_used.push_back(idx);
         first_written[idx] = 1'b1;
      end else begin
         if (!second_written[idx]) second_used.push_back(idx);
         second_written[idx] = 1'b1;
      end
   endtask

   // queue a pixel request with random unused fields
   task automatic add_pixel(index_type idx_a, index_type idx_b);
      request_type r;
      r.func           = pcf_pkg::FUNC_PIXEL;
      r.palette_select = 1'($urandom);
      r.entry_index    = index_type'($urandom);
      r.entry_color    = color_type'($urandom);
      r.first_index    = idx_a;
      r.second_index   = idx_b;
      request_q.push_back(r);
   endtask

   // random mix of writes and pixels, pixels only on written entries
   task automatic fill_random(int count);
      index_type ia;
      index_type ib;
      color_type color;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 40) begin
            case ($urandom_range(0, 9))
               0:       color = '0;
               1:       color = '1;
               default: color = color_type'($urandom);
            endcase
            add_write(1'($urandom), index_type'($urandom), color);
         end else begin
            ia = index_type'($urandom);
            ib = index_type'($urandom);
            if (!first_written[ia])
               ia = first_used[$urandom_range(0, first_used.size() - 1)];
            if (!second_written[ib])
               ib = second_used[$urandom_range(0, second_used.size() - 1)];
            add_pixel(ia, ib);
         end
      end
   endtask

   // wait until every request is taken and every pixel is back
   task automatic wait_idle();
      @(negedge clock);
      while (request_q.size() != 0 || req_ch.valid || pixel_q.size() != 0)
         @(negedge clock);
   endtask

   // write the weight register once the block has drained
   task automatic set_weight(weight_type w);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.blend_weight <= w;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      weight_model = w;
   endtask

   // request driver
   always @(posedge clock) begin
      request_type r;
      request_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            r.func           = req_ch.func;
            r.palette_select = req_ch.palette_select;
            r.entry_index    = req_ch.entry_index;
            r.entry_color    = req_ch.entry_color;
            r.first_index    = req_ch.first_index;
            r.second_index   = req_ch.second_index;
            track_request(r);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = request_q.pop_front();
               req_ch.valid          <= 1'b1;
               req_ch.func           <= nxt.func;
               req_ch.palette_select <= nxt.palette_select;
               req_ch.entry_index    <= nxt.entry_index;
               req_ch.entry_color    <= nxt.entry_color;
               req_ch.first_index    <= nxt.first_index;
               req_ch.second_index   <= nxt.second_index;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_arm)
         hold_left <= 300;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // response monitor and checker
   always @(posedge clock) begin
      color_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pixel_q.size() == 0) begin
               $error("out_pixel: no pixel expected, actual %h", rsp_ch.out_pixel);
               error_count++;
            end else begin
               want = pixel_q.pop_front();
               if (rsp_ch.out_pixel !== want) begin
                  $error("out_pixel: expected %h, actual %h", want, rsp_ch.out_pixel);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // run limit
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   // stimulus sequence
   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.func           = pcf_pkg::FUNC_WRITE;
      req_ch.palette_select = 1'b0;
      req_ch.entry_index    = '0;
      req_ch.entry_color    = '0;
      req_ch.first_index    = '0;
      req_ch.second_index   = '0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.blend_weight   = '0;
      hold_arm              = 1'b0;
      send_idle_pct         = 0;
      recv_stall_pct        = 0;
      error_count           = 0;
      weight_model          = '0;
      for (int i = 0; i < 256; i++) begin
         first_pal_model[i]  = '0;
         second_pal_model[i] = '0;
         first_written[i]    = 1'b0;
         second_written[i]   = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: corner entries and pure channels at the reset weight of zero
      add_write(1'b0, 8'h00, 16'h0000);
      add_write(1'b0, 8'hff, 16'hffff);
      add_write(1'b1, 8'h00, 16'hffff);
      add_write(1'b1, 8'hff, 16'h0000);
      add_write(1'b0, 8'h55, 16'hf800);
      add_write(1'b1, 8'haa, 16'h07e0);
      add_write(1'b0, 8'haa, 16'h001f);
      add_write(1'b1, 8'h55, 16'ha5a5);
      add_pixel(8'h00, 8'h00);
      add_pixel(8'hff, 8'hff);
      add_pixel(8'h00, 8'hff);
      add_pixel(8'hff, 8'h00);
      add_pixel(8'h55, 8'haa);
      add_pixel(8'haa, 8'h55);
      fill_random(160);

      // largest weight, sender mostly idle
      set_weight(5'd31);
      add_pixel(8'h00, 8'h00);
      add_pixel(8'hff, 8'hff);
      add_pixel(8'h55, 8'haa);
      send_idle_pct = 82;
      fill_random(170);

      // mid weight, receiver mostly stalled
      set_weight(weight_type'($urandom_range(2, 30)));
      send_idle_pct  = 0;
      recv_stall_pct = 82;
      fill_random(170);

      // smallest nonzero weight, both sides idling
      set_weight(5'd1);
      send_idle_pct  = 30;
      recv_stall_pct = 30;
      fill_random(170);

      // half weight, receiver holds off while requests keep coming
      set_weight(5'd16);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fill_random(170);
      @(posedge clock);
      hold_arm <= 1'b1;
      @(posedge clock);
      hold_arm <= 1'b0;

      // back to zero weight by an explicit write
      set_weight(5'd0);
      add_pixel(8'h00, 8'hff);
      add_pixel(8'haa, 8'h55);
      send_idle_pct  = 30;
      recv_stall_pct = 30;
      fill_random(150);

      // drain and watch for stray pixels
      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
src/pcf_pkg.sv
src/pcf_ifs.sv
src/pcf_palette_ram.sv
src/pcf_mix.sv
src/palette_crossfade_rgb565_core.sv
dv/palette_crossfade_rgb565_core_tb.sv
